@@ design/sync_header_frame_deframer_top_assert.svh @@
// assertion macros shared by the deframer rtl
// needs nothing else; files that check their own logic include this header
`ifndef SYNC_HEADER_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define SHFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ design/shfd_pkg.sv @@
// shared types and constants of the sync-header frame deframer
// no dependencies
package shfd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_SYNC_ERR  = 2'd2;
  localparam logic [1:0] KIND_LEN_ERR   = 2'd3;

  // header layout
  localparam int unsigned HDR_BYTES = 24;
  localparam logic [4:0]  HDR_LAST  = 5'(HDR_BYTES - 1);

  // one result as it leaves the core
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload;
    logic [31:0]        frame_length;
    logic signed [31:0] frame_number;
    logic signed [31:0] frame_count;
    logic               is_last;
  } shfd_result_t;

  // sync word "LalkA123", one byte per position
  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0: b = 8'h4C;
      3'd1: b = 8'h61;
      3'd2: b = 8'h6C;
      3'd3: b = 8'h6B;
      3'd4: b = 8'h41;
      3'd5: b = 8'h31;
      3'd6: b = 8'h32;
      3'd7: b = 8'h33;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/shfd_in_stage.sv @@
// input register of the deframer: holds one received byte until the core takes it
// depends on nothing but the clock and reset
module shfd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // free when empty or when the held byte leaves this cycle
  assign in_ready = !valid_r || take_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;

endmodule

@@ design/shfd_core.sv @@
// header parser and payload counter of the deframer
// depends on shfd_pkg and the assertion macro header
`include "sync_header_frame_deframer_top_assert.svh"

module shfd_core #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output shfd_pkg::shfd_result_t res_o
);
  import shfd_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  logic [1:0]              phase_r, phase_nxt;
  logic [4:0]              idx_r, idx_nxt;
  logic                    mismatch_r, mismatch_nxt;
  logic [63:0]             len_r, len_nxt;
  logic [31:0]             num_r, num_nxt;
  logic [31:0]             cnt_r, cnt_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;
  logic                    rem_last;
  logic                    too_large;

  // last payload byte when one or none remain
  assign rem_last  = (rem_r[LENGTH_WIDTH-1:1] == '0);
  assign too_large = ((len_nxt >> LENGTH_WIDTH) != 64'd0);

  // one byte of work
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    mismatch_nxt = mismatch_r;
    len_nxt      = len_r;
    num_nxt      = num_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (phase_r)
      PH_DATA: begin
        if (step_i) begin
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_PAYLOAD;
          res_o.payload = byte_i;
          res_o.is_last = rem_last;
          if (rem_last) begin
            phase_nxt    = PH_HEADER;
            idx_nxt      = '0;
            mismatch_nxt = 1'b0;
            rem_nxt      = '0;
          end else begin
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      PH_HEADER: begin
        if (step_i) begin
          // sync check and little-endian field capture
          if (idx_r[4:3] == 2'b00) begin
            if (byte_i != sync_byte(idx_r[2:0])) begin
              mismatch_nxt = 1'b1;
            end
          end else if (idx_r[4:3] == 2'b01) begin
            len_nxt = {byte_i, len_r[63:8]};
          end else if (idx_r[4:2] == 3'b100) begin
            num_nxt = {byte_i, num_r[31:8]};
          end else begin
            cnt_nxt = {byte_i, cnt_r[31:8]};
          end

          if (idx_r == HDR_LAST) begin
            idx_nxt = '0;
            if (mismatch_nxt) begin
              phase_nxt   = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_SYNC_ERR;
            end else if (too_large) begin
              phase_nxt   = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_LEN_ERR;
            end else if (len_nxt == 64'd0) begin
              res_valid_o   = 1'b1;
              res_o.kind    = KIND_EMPTY;
              res_o.is_last = 1'b1;
            end else begin
              rem_nxt   = len_nxt[LENGTH_WIDTH-1:0];
              phase_nxt = PH_DATA;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        // halted: bytes are dropped until reset
      end
    endcase

    // header fields of the current frame go with every result
    res_o.frame_length = len_nxt[31:0];
    res_o.frame_number = num_nxt;
    res_o.frame_count  = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      idx_r      <= '0;
      mismatch_r <= 1'b0;
      len_r      <= '0;
      num_r      <= '0;
      cnt_r      <= '0;
      rem_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      mismatch_r <= mismatch_nxt;
      len_r      <= len_nxt;
      num_r      <= num_nxt;
      cnt_r      <= cnt_nxt;
      rem_r      <= rem_nxt;
    end
  end

  // checks
  `SHFD_ASSERT_NXT(a_halt_sticky, clk, rst_n, phase_r == PH_HALT, phase_r == PH_HALT)
  `SHFD_ASSERT_IMP(a_halt_silent, clk, rst_n, phase_r == PH_HALT, !res_valid_o)
  `SHFD_ASSERT_IMP(a_data_emits, clk, rst_n, step_i && (phase_r == PH_DATA), res_valid_o)
  `SHFD_ASSERT_IMP(a_hdr_quiet, clk, rst_n, (phase_r == PH_HEADER) && (idx_r != HDR_LAST), !res_valid_o)
  `SHFD_ASSERT_IMP(a_rem_nonzero, clk, rst_n, phase_r == PH_DATA, rem_r != '0)

endmodule

@@ design/shfd_out_reg.sv @@
// result register of the deframer: holds one result until the sink takes it
// depends on shfd_pkg
module shfd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  logic                   res_valid_i,
  input  shfd_pkg::shfd_result_t res_i,
  output logic                   free_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output shfd_pkg::shfd_result_t res_o
);
  import shfd_pkg::*;

  logic         valid_r, valid_nxt;
  shfd_result_t res_r;

  // room for a new result when empty or being drained
  assign free_o = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = res_valid_i;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i && res_valid_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

@@ design/sync_header_frame_deframer_top.sv @@
// sync-header frame deframer, top level
// an accepted byte waits in the input register; its result is held in the result register
// throughput: one byte per clock unless the sink stalls; single pass to result register
// a stalled sink holds the result register and, behind it, the input register
// reset (synchronous, active low) returns to the header phase with all captures at zero
module sync_header_frame_deframer_top #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_payload_byte,
  output logic [31:0]        out_frame_length,
  output logic signed [31:0] out_frame_number,
  output logic signed [31:0] out_frame_count,
  output logic               out_is_last
);
  import shfd_pkg::*;

  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         out_free;
  logic         step;
  logic         res_valid;
  shfd_result_t res;
  shfd_result_t res_q;

  // a held byte is worked on when the result register has room
  assign step = stage_valid && out_free;

  shfd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .take_i       (step),
    .valid_o      (stage_valid),
    .byte_o       (stage_byte)
  );

  shfd_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .byte_i      (stage_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  shfd_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res_o       (res_q)
  );

  // result fields to ports
  assign out_result_kind  = res_q.kind;
  assign out_payload_byte = res_q.payload;
  assign out_frame_length = res_q.frame_length;
  assign out_frame_number = res_q.frame_number;
  assign out_frame_count  = res_q.frame_count;
  assign out_is_last      = res_q.is_last;

endmodule
